FILE: src/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types and codes of the handle table allocator.
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam int SLOTS_DEF        = 256;
    localparam int MAX_LIVE_DEF     = 256;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam logic [31:0] START_HANDLE_RST = 32'd1;

    // configuration register index (word address)
    localparam logic REG_START_HANDLE = 1'b0;

    // commands
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_RETIRE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] handle;
        logic [15:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle_out;
        logic [15:0] payload_out;
    } t_out_item;

endpackage

FILE: src/hta_ram.sv
// ----------------------------------------------------------------------------
// hta_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/handle_table_allocator_core.sv
// ----------------------------------------------------------------------------
// handle_table_allocator_core
// Slot table that hands out nonzero 32-bit handles and retires/looks them up.
// ----------------------------------------------------------------------------
// One item at a time. The slot table lives in a single RAM with one read and
// one write port; every entry holds {valid, handle, payload}. After reset the
// block walks the RAM once to clear it, with o_ready low (configuration
// writes are taken meanwhile). A register item probes one candidate slot per
// cycle through the RAM read port, starting at the next-handle counter, and
// walks on until it finds a free slot or has tried the whole table. Retire and
// lookup go through read, check and hand-off states. Items rejected outright
// (full table, already registered, zero-handle retire, unused command) go
// straight to the hand-off. The hand-off cycle repeats while the output
// register still holds a result that i_ready has not taken. The result goes
// through an output register, so the next item is accepted while the previous
// result still waits for i_ready. Writing start_handle at word 0 loads the
// next-handle counter.
// ----------------------------------------------------------------------------
module handle_table_allocator_core #(
    parameter int SLOTS        = hta_pkg::SLOTS_DEF,
    parameter int MAX_LIVE     = hta_pkg::MAX_LIVE_DEF,
    parameter int PAYLOAD_BITS = hta_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_valid,
    output logic                o_ready,
    input  hta_pkg::t_in_item   i_in_item,
    // result output
    output logic                o_valid,
    input  logic                i_ready,
    output hta_pkg::t_out_item  o_out_item,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int LIVE_W = $clog2(MAX_LIVE + 1);
    localparam int WORD_W = 1 + 32 + PAYLOAD_BITS;
    localparam logic [31:0]       SLOTS_H   = 32'(SLOTS);
    localparam logic [CNT_W-1:0]  PROBE_END = CNT_W'(SLOTS);
    localparam logic [LIVE_W-1:0] LIVE_MAX  = LIVE_W'(MAX_LIVE);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_ISSUE = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [SLOT_W-1:0]       r_clr_idx, n_clr_idx;
    logic [31:0]             r_start_handle, n_start_handle;
    logic [31:0]             r_next_handle, n_next_handle;
    logic [LIVE_W-1:0]       r_live, n_live;
    logic [1:0]              r_cmd, n_cmd;
    logic [31:0]             r_handle, n_handle;
    logic [15:0]             r_payload, n_payload;
    logic [31:0]             r_cand, n_cand;
    logic [31:0]             r_rd_cand, n_rd_cand;
    logic                    r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]        r_probe_cnt, n_probe_cnt;
    hta_pkg::t_out_item      r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    hta_pkg::t_out_item      r_out, n_out;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;

    logic                    rd_valid;
    logic [31:0]             rd_handle;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [63:0]             rd_payload_ext;
    logic [63:0]             in_payload_ext;
    logic [PAYLOAD_BITS-1:0] payload_st;
    logic                    cfg_wr;
    logic                    accept;
    logic                    issue;

    // Handle 0 is never given out: a candidate that wraps to 0 moves up a table.
    function automatic logic [31:0] skip_zero(input logic [31:0] h);
        skip_zero = (h == 32'd0) ? SLOTS_H : h;
    endfunction

    hta_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_valid       = ram_rdata[WORD_W-1];
    assign rd_handle      = ram_rdata[WORD_W-2 -: 32];
    assign rd_payload     = ram_rdata[PAYLOAD_BITS-1:0];
    assign rd_payload_ext = 64'(rd_payload);
    // keep the low PAYLOAD_BITS bits of the item payload
    assign in_payload_ext = 64'(r_payload);
    assign payload_st     = in_payload_ext[PAYLOAD_BITS-1:0];

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == hta_pkg::REG_START_HANDLE) ? r_start_handle : 32'd0;

    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

    // issue one probe per cycle until every slot has been tried
    assign issue = (r_probe_cnt < PROBE_END);

    // read address: the scan candidate, else the item's own slot
    assign ram_raddr = (r_state == S_SCAN) ? r_cand[SLOT_W-1:0] : r_handle[SLOT_W-1:0];

    always_comb begin
        n_state        = r_state;
        n_clr_idx      = r_clr_idx;
        n_start_handle = r_start_handle;
        n_next_handle  = r_next_handle;
        n_live         = r_live;
        n_cmd          = r_cmd;
        n_handle       = r_handle;
        n_payload      = r_payload;
        n_cand         = r_cand;
        n_rd_cand      = r_rd_cand;
        n_rd_vld       = r_rd_vld;
        n_probe_cnt    = r_probe_cnt;
        n_res          = r_res;
        n_out_valid    = r_out_valid;
        n_out          = r_out;
        ram_we         = 1'b0;
        ram_waddr      = r_handle[SLOT_W-1:0];
        ram_wdata      = '0;

        // drain the output register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        // config write reloads the next-handle counter
        if (cfg_wr && (paddr[2] == hta_pkg::REG_START_HANDLE)) begin
            n_start_handle = pwdata;
            n_next_handle  = pwdata;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == {SLOT_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_cmd                 = i_in_item.cmd;
                    n_handle              = i_in_item.handle;
                    n_payload             = i_in_item.payload;
                    n_res.handle_out      = i_in_item.handle;
                    n_res.payload_out     = 16'd0;
                    n_res.status          = hta_pkg::ST_NOT_FOUND;
                    n_state               = S_DONE;
                    unique case (i_in_item.cmd)
                        hta_pkg::CMD_REGISTER: begin
                            if (r_live >= LIVE_MAX) begin
                                n_res.status = hta_pkg::ST_FULL;
                            end else if (i_in_item.handle != 32'd0) begin
                                n_res.status = hta_pkg::ST_ALREADY;
                            end else begin
                                n_cand      = skip_zero(r_next_handle);
                                n_probe_cnt = '0;
                                n_rd_vld    = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        hta_pkg::CMD_RETIRE: begin
                            if (i_in_item.handle == 32'd0) begin
                                n_res.status = hta_pkg::ST_ZERO;
                            end else begin
                                n_state = S_ISSUE;
                            end
                        end
                        hta_pkg::CMD_LOOKUP: begin
                            n_state = S_ISSUE;
                        end
                        default: begin
                            n_res.status = hta_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // probe pipeline: read issued now, checked next cycle
                n_rd_vld  = issue;
                n_rd_cand = r_cand;
                if (issue) begin
                    n_cand      = skip_zero(r_cand + 32'd1);
                    n_probe_cnt = r_probe_cnt + 1'b1;
                end
                if (r_rd_vld && !rd_valid) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_rd_cand[SLOT_W-1:0];
                    ram_wdata        = {1'b1, r_rd_cand, payload_st};
                    n_next_handle    = r_rd_cand + 32'd1;
                    n_live           = r_live + 1'b1;
                    n_res.status     = hta_pkg::ST_OK;
                    n_res.handle_out = r_rd_cand;
                    n_state          = S_DONE;
                end else if (!issue && !r_rd_vld) begin
                    // every slot taken
                    n_res.status = hta_pkg::ST_FULL;
                    n_state      = S_DONE;
                end
            end

            S_ISSUE: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_state = S_DONE;
                if (r_cmd == hta_pkg::CMD_RETIRE) begin
                    if (rd_valid) begin
                        // free the slot even on a mismatch
                        ram_we = 1'b1;
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                        if ((rd_handle == r_handle) && (rd_payload == payload_st)) begin
                            n_res.status = hta_pkg::ST_OK;
                        end
                    end
                end else if (rd_valid && (rd_handle == r_handle)) begin
                    n_res.status      = hta_pkg::ST_OK;
                    n_res.payload_out = rd_payload_ext[15:0];
                end
            end

            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_idx      <= '0;
            r_start_handle <= hta_pkg::START_HANDLE_RST;
            r_next_handle  <= hta_pkg::START_HANDLE_RST;
            r_live         <= '0;
            r_rd_vld       <= 1'b0;
            r_probe_cnt    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_idx      <= n_clr_idx;
            r_start_handle <= n_start_handle;
            r_next_handle  <= n_next_handle;
            r_live         <= n_live;
            r_rd_vld       <= n_rd_vld;
            r_probe_cnt    <= n_probe_cnt;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_handle  <= n_handle;
        r_payload <= n_payload;
        r_cand    <= n_cand;
        r_rd_cand <= n_rd_cand;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // scan never stores handle 0
    a_no_zero_handle: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        (ram_we && (r_state == S_SCAN)) |-> (ram_wdata[WORD_W-2 -: 32] != 32'd0))
        else $error("scan stored handle zero");

    // live count stays within the table limit
    a_live_bound: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        (r_live <= LIVE_MAX))
        else $error("live count above limit");

    // probe counter never walks past the table
    a_probe_bound: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        (r_probe_cnt <= PROBE_END))
        else $error("probe count past table size");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        accept |=> (r_state != S_IDLE))
        else $error("item accepted but block stayed idle");

endmodule

FILE: tb/handle_table_allocator_checker.sv
// ----------------------------------------------------------------------------
// handle_table_allocator_checker
// Watches the item, result and configuration channels of the handle table
// allocator. Predicts every result from its own copy of the slot table and
// compares each returned result field by field, oldest first.
// ----------------------------------------------------------------------------
module handle_table_allocator_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  hta_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hta_pkg::t_out_item  i_out_item,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = hta_pkg::SLOTS_DEF;
    localparam int MAX_LIVE = hta_pkg::MAX_LIVE_DEF;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PRINT_CAP = 100;

    logic               entry_used   [SLOTS];
    logic [31:0]        entry_handle [SLOTS];
    logic [15:0]        entry_data   [SLOTS];
    logic [31:0]        handle_cursor;
    int                 used_count;
    hta_pkg::t_out_item awaited_results [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // Work out the result of one item and advance the table copy.
    function automatic hta_pkg::t_out_item table_result(input hta_pkg::t_in_item it);
        hta_pkg::t_out_item    res;
        logic [31:0]           base;
        logic [31:0]           cand;
        logic [SLOT_W-1:0]     s;
        logic                  found;
        res.status      = hta_pkg::ST_NOT_FOUND;
        res.handle_out  = it.handle;
        res.payload_out = '0;
        s = it.handle[SLOT_W-1:0];
        case (it.cmd)
            hta_pkg::CMD_REGISTER: begin
                if (used_count >= MAX_LIVE) begin
                    res.status = hta_pkg::ST_FULL;
                end else if (it.handle != '0) begin
                    res.status = hta_pkg::ST_ALREADY;
                end else begin
                    res.status = hta_pkg::ST_FULL;
                    base  = handle_cursor;
                    found = 1'b0;
                    for (int i = 0; i < SLOTS && !found; i++) begin
                        cand = base + 32'(i);
                        // never hand out handle zero: skip a whole table lap
                        if (cand == '0) begin
                            base = base + 32'(SLOTS);
                            cand = base + 32'(i);
                        end
                        s = cand[SLOT_W-1:0];
                        if (!entry_used[s]) begin
                            entry_used[s]   = 1'b1;
                            entry_handle[s] = cand;
                            entry_data[s]   = it.payload;
                            handle_cursor   = cand + 32'd1;
                            used_count++;
                            res.status      = hta_pkg::ST_OK;
                            res.handle_out  = cand;
                            found           = 1'b1;
                        end
                    end
                end
            end
            hta_pkg::CMD_RETIRE: begin
                if (it.handle == '0) begin
                    res.status = hta_pkg::ST_ZERO;
                end else if (entry_used[s]) begin
                    // a mismatching retire still frees the slot
                    res.status = (entry_handle[s] == it.handle && entry_data[s] == it.payload)
                                 ? hta_pkg::ST_OK : hta_pkg::ST_NOT_FOUND;
                    entry_used[s] = 1'b0;
                    if (used_count > 0)
                        used_count--;
                end
            end
            hta_pkg::CMD_LOOKUP: begin
                if (entry_used[s] && entry_handle[s] == it.handle) begin
                    res.status      = hta_pkg::ST_OK;
                    res.payload_out = entry_data[s];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        hta_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                entry_used[i] = 1'b0;
            handle_cursor = hta_pkg::START_HANDLE_RST;
            used_count    = 0;
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == {hta_pkg::REG_START_HANDLE, 2'b00})
                handle_cursor = i_pwdata;
            // compare before taking a new item so a result never meets its own item
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing awaited: %p", i_out_item));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d (handle %h)",
                                        i_out_item.status, want.status, want.handle_out));
                    if (i_out_item.handle_out !== want.handle_out)
                        report_mismatch($sformatf("handle_out got %h want %h",
                                        i_out_item.handle_out, want.handle_out));
                    if (i_out_item.payload_out !== want.payload_out)
                        report_mismatch($sformatf("payload_out got %h want %h (handle %h)",
                                        i_out_item.payload_out, want.payload_out,
                                        want.handle_out));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(table_result(i_in_item));
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the handle table allocator with a directed set of corner items, a
// table fill to capacity and three phases of random register, retire and
// lookup traffic under varying back-pressure. A separate checker predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS            = hta_pkg::SLOTS_DEF;
    localparam int SLOT_W           = $clog2(SLOTS);
    localparam int RANDOM_PER_PHASE = 450;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = SLOTS + 8;
    // the limit sits well above the length of a full table walk plus stalls
    localparam int WATCHDOG_LIMIT   = 16 * SLOTS;
    localparam int POOL_KEEP        = 24;

    localparam logic [1:0] CMD_UNUSED        = 2'd3;
    localparam logic [2:0] START_HANDLE_ADDR = {hta_pkg::REG_START_HANDLE, 2'b00};

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] payload;
    } t_live_entry;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    hta_pkg::t_in_item  i_in_item;
    logic               o_valid;
    logic               i_ready;
    hta_pkg::t_out_item o_out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 30;
    int          recv_idle_pct = 49;
    int          idle_cycles   = 0;

    // items in flight, oldest first, and handles known to be live
    hta_pkg::t_in_item in_flight [$];
    t_live_entry       live_pool [$];

    handle_table_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_item  (i_in_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    handle_table_allocator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: stall at random, decided fresh at each falling edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Track in-flight items so that fresh handles join the live pool, and
    // end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        hta_pkg::t_in_item sent;
        if (o_valid && i_ready && in_flight.size() != 0) begin
            sent = in_flight.pop_front();
            if (sent.cmd == hta_pkg::CMD_REGISTER && o_out_item.status == hta_pkg::ST_OK)
                live_pool.push_back({o_out_item.handle_out, sent.payload});
        end
        if (i_valid && o_ready)
            in_flight.push_back(i_in_item);

        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic hta_pkg::t_in_item make_item(input logic [1:0] cmd,
                                                    input logic [31:0] handle,
                                                    input logic [15:0] payload);
        hta_pkg::t_in_item it;
        it.cmd     = cmd;
        it.handle  = handle;
        it.payload = payload;
        return it;
    endfunction

    function automatic logic [31:0] nonzero_handle();
        logic [31:0] h;
        do
            h = $urandom();
        while (h == '0);
        return h;
    endfunction

    // Same slot, different upper bits: a stale or forged handle.
    function automatic logic [31:0] alias_of(input logic [31:0] h);
        logic [31:0] a;
        a = h ^ (32'($urandom_range(1, 2 ** (32 - SLOT_W) - 1)) << SLOT_W);
        return (a == '0) ? h : a;
    endfunction

    // Pull one random entry out of the live pool.
    function automatic t_live_entry take_from_pool();
        int          idx;
        t_live_entry e;
        idx = $urandom_range(0, live_pool.size() - 1);
        e   = live_pool[idx];
        live_pool.delete(idx);
        return e;
    endfunction

    // Mostly well-formed traffic on live handles, with a share of noise.
    function automatic hta_pkg::t_in_item pick_item();
        hta_pkg::t_in_item it;
        t_live_entry       e;
        int unsigned       roll;
        int unsigned       twist;
        roll  = $urandom_range(0, 99);
        twist = $urandom_range(0, 19);
        it    = make_item(hta_pkg::CMD_REGISTER, '0, 16'($urandom()));
        if (live_pool.size() == 0 && roll >= 45 && roll < 90)
            roll = 0;
        if (roll < 40) begin
            // plain register, handle zero
        end else if (roll < 45) begin
            it.handle = nonzero_handle();
        end else if (roll < 70) begin
            e  = take_from_pool();
            it = make_item(hta_pkg::CMD_RETIRE, e.handle, e.payload);
            if (twist == 0)
                it.payload = e.payload ^ 16'($urandom_range(1, 16'hFFFF));
            else if (twist == 1)
                it.handle = alias_of(e.handle);
        end else if (roll < 90) begin
            e  = live_pool[$urandom_range(0, live_pool.size() - 1)];
            it = make_item(hta_pkg::CMD_LOOKUP, (twist < 2) ? alias_of(e.handle) : e.handle,
                           16'($urandom()));
        end else if (roll < 95) begin
            it = make_item(hta_pkg::CMD_RETIRE, (twist == 0) ? '0 : 32'($urandom()),
                           16'($urandom()));
        end else if (roll < 98) begin
            it = make_item(hta_pkg::CMD_LOOKUP, (twist < 5) ? '0 : 32'($urandom()),
                           16'($urandom()));
        end else begin
            it = make_item(CMD_UNUSED, $urandom(), 16'($urandom()));
        end
        return it;
    endfunction

    // Offer one item and return at the edge that takes it.
    task automatic send_item(input hta_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Hold off the sender until every awaited result is back, then settle.
    task automatic wait_drained(input int settle);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_start_handle(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_HANDLE_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase();
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // now and then, let the block run completely dry
            if ($urandom_range(0, 99) < 2)
                wait_drained(0);
            send_item(pick_item());
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_ready   = 1'b0;
        i_in_item = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners. Start just below the top so the counter wraps.
        write_start_handle(32'hFFFF_FFFE);
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'hFFFF));
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h0000));
        // counter now wraps through zero: advance a whole lap
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'hA5A5));
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 16'h1234));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'hFFFF_FFFE, 16'h0000));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'h0000_0000, 16'h0000));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'h0000_0100, 16'h0000));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'h0000_01FE, 16'h0000));
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'h0000_0000, 16'hFFFF));
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'h0000_0005, 16'h0000));
        // wrong payload, then wrong upper handle bits: both free the slot
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'hFFFF_FFFE, 16'h0001));
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'h0000_01FF, 16'h0000));
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'h0000_0100, 16'hA5A5));
        send_item(make_item(CMD_UNUSED,            32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'hFFFF_FFFF, 16'h0000));
        send_item(make_item(hta_pkg::CMD_RETIRE,   32'hFFFF_FFFF, 16'h0000));
        wait_drained(SETTLE_CYCLES);
        write_start_handle(32'h0000_0000);
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h5A5A));
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h0001));
        wait_drained(SETTLE_CYCLES);
        write_start_handle(32'hFFFF_FFFF);
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h8000));
        // slots just past zero are taken: walk forward to a free one
        send_item(make_item(hta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h7FFF));
        send_item(make_item(hta_pkg::CMD_LOOKUP,   32'h0000_0102, 16'h0000));
        wait_drained(SETTLE_CYCLES);
        live_pool.delete();

        // Phase one: slow sender, slower receiver.
        write_start_handle($urandom());
        random_phase();

        // Phase two: roles swapped; fill the table past capacity, then retire all but POOL_KEEP live handles.
        wait_drained(SETTLE_CYCLES);
        send_idle_pct = 49;
        recv_idle_pct = 30;
        write_start_handle(32'hFFFF_FF00);
        for (int n = 0; n < SLOTS + 4; n++)
            send_item(make_item(hta_pkg::CMD_REGISTER, '0, 16'($urandom())));
        // full table wins over an already-registered handle
        send_item(make_item(hta_pkg::CMD_REGISTER, nonzero_handle(), 16'($urandom())));
        wait_drained(0);
        while (live_pool.size() > POOL_KEEP) begin
            t_live_entry e;
            e = take_from_pool();
            send_item(make_item(hta_pkg::CMD_RETIRE, e.handle, e.payload));
        end
        random_phase();

        // Phase three: no idling on either side, counter back at its reset value.
        wait_drained(SETTLE_CYCLES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_start_handle(hta_pkg::START_HANDLE_RST);
        random_phase();

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
